>>> rtl/wcc_pkg.sv
// Shared widths, codes and control structs for the weighted concordance block.
`timescale 1ns / 1ps
`default_nettype none
package wcc_pkg;

    // default log2 of the pair count the accumulators cover
    localparam int LOG2_MAX_PAIRS_DEF = 16;

    // signed width of the finish arithmetic, sized for the widest accumulators
    localparam int BW = 136;
    // magnitude operand width of the limb multiplier
    localparam int MW = 128;
    localparam int LIMB = 32;
    localparam int LIMB_LOG = 5;
    localparam int NLIMB = MW / LIMB;
    localparam int LIMB_IDX_W = 2;
    // quotient bits before rounding to Q1.30
    localparam int QW = 31;
    localparam int QCNT_W = 5;

    localparam logic [15:0] WEIGHT_ONE = 16'd256;
    localparam logic signed [BW-1:0] BIG_WEIGHT_ONE = BW'(256);

    // configuration register indexes
    localparam logic CFG_CORRECTION = 1'b0;
    localparam logic CFG_WEIGHT     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WZERO = 2'd1,
        ST_DZERO = 2'd2
    } t_status;

    // finish multiplications, in issue order
    typedef enum logic [3:0] {
        OP_WSAA, OP_SASA, OP_WSPP, OP_SPSP, OP_WSAP,
        OP_SASP, OP_DSQ, OP_NUMC, OP_DENC, OP_WD
    } t_mop;

    typedef struct packed {
        logic    in_load;
        logic    prod_en;
        logic    wprod_en;
        logic    acc_en;
        logic    clr_sums;
        logic    mul_start;
        t_mop    mop;
        logic    setup;
        logic    add_d;
        logic    div_start;
        logic    out_load;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic wzero;
        logic den_zero;
        logic mul_done;
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/wcc_mul.sv
// Signed multiplier over 32-bit limbs, one partial product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wcc_mul
    import wcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [BW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic                      o_done,
    output logic signed [BW-1:0]      o_prod
);

    localparam logic [LIMB_IDX_W-1:0] LAST_LIMB = LIMB_IDX_W'(NLIMB - 1);

    logic [MW-1:0]           r_am, r_bm;
    logic                    r_neg;
    logic [LIMB_IDX_W-1:0]   r_i, r_j;
    logic                    r_busy, r_ppv, r_fin, r_done;
    logic [2*LIMB-1:0]       r_pp;
    logic [LIMB_IDX_W:0]     r_sh;
    logic [BW-1:0]           r_acc;
    logic signed [BW-1:0]    a_mag, b_mag;
    logic [2*LIMB-1:0]       pp;

    assign a_mag = i_a[BW-1] ? -i_a : i_a;
    assign b_mag = i_b[BW-1] ? -i_b : i_b;
    assign pp    = r_am[r_i*LIMB +: LIMB] * r_bm[r_j*LIMB +: LIMB];

    // control: limb counters and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            r_ppv  <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_j    <= '0;
            end else if (r_busy) begin
                if (r_j == LAST_LIMB) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_LIMB) begin
                        r_busy <= 1'b0;
                        r_fin  <= 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // data: operand magnitudes, partial product, shifted accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= a_mag[MW-1:0];
            r_bm  <= b_mag[MW-1:0];
            r_neg <= i_a[BW-1] ^ i_b[BW-1];
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= r_acc + (BW'(r_pp) << {r_sh, {LIMB_LOG{1'b0}}});
        end
        r_pp <= pp;
        r_sh <= {1'b0, r_i} + {1'b0, r_j};
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);

endmodule
`default_nettype wire

>>> rtl/wcc_div.sv
// Restoring divider giving a rounded, saturated Q1.30 quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wcc_div
    import wcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [BW-1:0] i_num,
    input  wire logic signed [BW-1:0] i_den,
    output logic                      o_done,
    output logic signed [31:0]        o_quot
);

    logic [BW-1:0]       r_n, r_d;
    logic [QW-1:0]       r_q;
    logic [QCNT_W-1:0]   r_cnt;
    logic                r_busy, r_done, r_neg, r_sat;
    logic signed [BW-1:0] n_mag, d_mag;
    logic [BW-1:0]       sh;
    logic                ge;
    logic [QW:0]         q_inc;
    logic [QW-1:0]       mag;

    assign n_mag = i_num[BW-1] ? -i_num : i_num;
    assign d_mag = i_den[BW-1] ? -i_den : i_den;
    assign sh    = {r_n[BW-2:0], 1'b0};
    assign ge    = (sh >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                // magnitude one or more saturates without iterating
                if ($unsigned(n_mag) >= $unsigned(d_mag)) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= n_mag;
            r_d   <= d_mag;
            r_q   <= '0;
            r_neg <= i_num[BW-1] ^ i_den[BW-1];
            r_sat <= ($unsigned(n_mag) >= $unsigned(d_mag));
        end else if (r_busy) begin
            r_n <= ge ? (sh - r_d) : sh;
            r_q <= {r_q[QW-2:0], ge};
        end
    end

    // round half away from zero, then apply sign
    assign q_inc  = {1'b0, r_q} + 1'b1;
    assign mag    = r_sat ? QW'(32'd1 << 30) : q_inc[QW:1];
    assign o_quot = r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign o_done = r_done;

endmodule
`default_nettype wire

>>> rtl/wcc_dp.sv
// Datapath: pair products, running sums, finish arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module wcc_dp
    import wcc_pkg::*;
#(
    parameter int LOG2_MAX_PAIRS = LOG2_MAX_PAIRS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_weight_enable,
    input  wire logic signed [15:0] i_actual_value,
    input  wire logic signed [15:0] i_predicted_value,
    input  wire logic [15:0]        i_sample_weight,
    input  wire logic               i_last_pair,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    output logic signed [31:0]      o_ccc_value,
    output logic [1:0]              o_result_status
);

    localparam int WT  = 16 + LOG2_MAX_PAIRS;
    localparam int SUM = 32 + LOG2_MAX_PAIRS;
    localparam int SQ  = 48 + LOG2_MAX_PAIRS;

    // input word and products
    logic signed [15:0] r_a, r_p;
    logic [15:0]        r_w;
    logic               r_last;
    logic signed [31:0] r_aa, r_pp, r_ap;
    logic signed [32:0] r_wa, r_wp;
    logic [47:0]        r_waa, r_wpp;
    logic signed [47:0] r_wap;
    logic signed [48:0] wap_full;

    // running sums
    logic [WT-1:0]         r_wt;
    logic signed [SUM-1:0] r_sa, r_sp;
    logic [SQ-1:0]         r_saa, r_spp;
    logic signed [SQ-1:0]  r_sap;

    // finish terms
    logic signed [BW-1:0] r_va, r_vp, r_cv, r_d, r_num, r_den;
    logic signed [BW-1:0] wb, sab, spb, saab, sppb, sapb, dsb, cb;
    logic signed [BW-1:0] op_a, op_b, prod;
    logic signed [31:0]   quot;
    logic                 mul_done, div_done;

    assign wap_full = $signed({1'b0, r_w}) * r_ap;

    // per pair: load, products, weighted products, accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_a    <= i_actual_value;
            r_p    <= i_predicted_value;
            r_w    <= i_weight_enable ? i_sample_weight : WEIGHT_ONE;
            r_last <= i_last_pair;
        end
        if (i_cmd.prod_en) begin
            r_aa <= r_a * r_a;
            r_pp <= r_p * r_p;
            r_ap <= r_a * r_p;
            r_wa <= $signed({1'b0, r_w}) * r_a;
            r_wp <= $signed({1'b0, r_w}) * r_p;
        end
        if (i_cmd.wprod_en) begin
            r_waa <= r_w * r_aa[30:0];
            r_wpp <= r_w * r_pp[30:0];
            r_wap <= $signed(wap_full[47:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_sums) begin
            r_wt  <= '0;
            r_sa  <= '0;
            r_sp  <= '0;
            r_saa <= '0;
            r_spp <= '0;
            r_sap <= '0;
        end else begin
            if (i_cmd.wprod_en) begin
                r_wt <= r_wt + WT'(r_w);
                r_sa <= r_sa + SUM'(r_wa);
                r_sp <= r_sp + SUM'(r_wp);
            end
            if (i_cmd.acc_en) begin
                r_saa <= r_saa + SQ'(r_waa);
                r_spp <= r_spp + SQ'(r_wpp);
                r_sap <= r_sap + SQ'(r_wap);
            end
        end
    end

    // sums widened to the finish width
    assign wb   = BW'($signed({1'b0, r_wt}));
    assign sab  = BW'(r_sa);
    assign spb  = BW'(r_sp);
    assign saab = BW'($signed({1'b0, r_saa}));
    assign sppb = BW'($signed({1'b0, r_spp}));
    assign sapb = BW'(r_sap);
    assign dsb  = sab - spb;
    assign cb   = wb - BIG_WEIGHT_ONE;

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.mop)
            OP_WSAA: begin op_a = wb;    op_b = saab; end
            OP_SASA: begin op_a = sab;   op_b = sab;  end
            OP_WSPP: begin op_a = wb;    op_b = sppb; end
            OP_SPSP: begin op_a = spb;   op_b = spb;  end
            OP_WSAP: begin op_a = wb;    op_b = sapb; end
            OP_SASP: begin op_a = sab;   op_b = spb;  end
            OP_DSQ:  begin op_a = dsb;   op_b = dsb;  end
            OP_NUMC: begin op_a = r_num; op_b = cb;   end
            OP_DENC: begin op_a = r_den; op_b = cb;   end
            OP_WD:   begin op_a = wb;    op_b = r_d;  end
            default: begin op_a = wb;    op_b = saab; end
        endcase
    end

    wcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // product write-back and the add steps
    always_ff @(posedge i_clk) begin
        if (mul_done) begin
            unique case (i_cmd.mop)
                OP_WSAA: r_va  <= prod;
                OP_SASA: r_va  <= r_va - prod;
                OP_WSPP: r_vp  <= prod;
                OP_SPSP: r_vp  <= r_vp - prod;
                OP_WSAP: r_cv  <= prod;
                OP_SASP: r_cv  <= r_cv - prod;
                OP_DSQ:  r_d   <= prod;
                OP_NUMC: r_num <= prod;
                OP_DENC: r_den <= prod;
                OP_WD:   r_den <= r_den + prod;
                default: r_va  <= r_va;
            endcase
        end else if (i_cmd.setup) begin
            r_num <= r_cv + r_cv;
            r_den <= r_va + r_vp;
        end else if (i_cmd.add_d) begin
            r_den <= r_den + r_d;
        end
    end

    wcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ccc_value     <= (i_cmd.status == ST_OK) ? quot : '0;
            o_result_status <= i_cmd.status;
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.wzero    = (r_wt == '0);
    assign o_stat.den_zero = (r_den == '0);
    assign o_stat.mul_done = mul_done;
    assign o_stat.div_done = div_done;

endmodule
`default_nettype wire

>>> rtl/wcc_ctrl.sv
// Controller: sequences pair accumulation, finish steps and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module wcc_ctrl
    import wcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_correction_enable,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_WPROD, S_ACC, S_CHK, S_MSTART, S_MWAIT,
        S_SETUP, S_ADDD, S_DIVCHK, S_DWAIT, S_DONE
    } t_state;

    t_state  r_state;
    t_mop    r_mop;
    t_status r_status;
    logic    r_out_valid;
    logic    out_load;

    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd.in_load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prod_en   = (r_state == S_PROD);
        o_cmd.wprod_en  = (r_state == S_WPROD);
        o_cmd.acc_en    = (r_state == S_ACC);
        o_cmd.clr_sums  = out_load;
        o_cmd.mul_start = (r_state == S_MSTART);
        o_cmd.mop       = r_mop;
        o_cmd.setup     = (r_state == S_SETUP);
        o_cmd.add_d     = (r_state == S_ADDD);
        o_cmd.div_start = (r_state == S_DIVCHK) && !i_stat.den_zero;
        o_cmd.out_load  = out_load;
        o_cmd.status    = r_status;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mop       <= OP_WSAA;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_PROD;
                S_PROD:  r_state <= S_WPROD;
                S_WPROD: r_state <= S_ACC;
                S_ACC:   r_state <= i_stat.last ? S_CHK : S_IDLE;
                S_CHK: begin
                    if (i_stat.wzero) begin
                        r_status <= ST_WZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_mop   <= OP_WSAA;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (i_stat.mul_done) begin
                        r_state <= S_MSTART;
                        unique case (r_mop)
                            OP_WSAA: r_mop <= OP_SASA;
                            OP_SASA: r_mop <= OP_WSPP;
                            OP_WSPP: r_mop <= OP_SPSP;
                            OP_SPSP: r_mop <= OP_WSAP;
                            OP_WSAP: r_mop <= OP_SASP;
                            OP_SASP: r_state <= S_SETUP;
                            OP_DSQ: begin
                                if (i_correction_enable) r_mop <= OP_NUMC;
                                else r_state <= S_ADDD;
                            end
                            OP_NUMC: r_mop <= OP_DENC;
                            OP_DENC: r_mop <= OP_WD;
                            OP_WD:   r_state <= S_DIVCHK;
                            default: r_state <= S_DIVCHK;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_mop   <= OP_DSQ;
                    r_state <= S_MSTART;
                end
                S_ADDD: r_state <= S_DIVCHK;
                S_DIVCHK: begin
                    if (i_stat.den_zero) begin
                        r_status <= ST_DZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (i_stat.div_done) begin
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE:  if (out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/weighted_concordance_correlation.sv
// Top level: weighted concordance correlation, configuration registers and wiring.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready   | actual, predicted, weight, last_pair
//  result   | o_out_valid / i_out_ready | ccc_value (Q1.30), result_status
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each pair steps through accept, products, weighted products and accumulate.
// A last pair adds the finish: ten 136-bit products (seven without correction) on one
// 32x32 limb multiplier, then a zero-denominator check and a 31-step divider, which
// skips its steps when the quotient saturates.
// Synchronous active-low reset clears the sums and the configuration.
// A result waits in the output register; a new vector is taken only after it loads.
`timescale 1ns / 1ps
`default_nettype none
module weighted_concordance_correlation
    import wcc_pkg::*;
#(
    parameter int LOG2_MAX_PAIRS = LOG2_MAX_PAIRS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic               i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_actual_value,
    input  wire logic signed [15:0] i_predicted_value,
    input  wire logic [15:0]        i_sample_weight,
    input  wire logic               i_last_pair,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_ccc_value,
    output logic [1:0]              o_result_status
);

    logic  r_correction_enable, r_weight_enable;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_correction_enable <= 1'b0;
            r_weight_enable     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CORRECTION: r_correction_enable <= i_cfg_data;
                CFG_WEIGHT:     r_weight_enable     <= i_cfg_data;
                default:        r_weight_enable     <= r_weight_enable;
            endcase
        end
    end

    wcc_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_correction_enable (r_correction_enable),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_stat              (stat),
        .o_cmd               (cmd)
    );

    wcc_dp #(
        .LOG2_MAX_PAIRS (LOG2_MAX_PAIRS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_weight_enable   (r_weight_enable),
        .i_actual_value    (i_actual_value),
        .i_predicted_value (i_predicted_value),
        .i_sample_weight   (i_sample_weight),
        .i_last_pair       (i_last_pair),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_ccc_value       (o_ccc_value),
        .o_result_status   (o_result_status)
    );

endmodule
`default_nettype wire
